[rtl/core/lzwd_pkg.sv]
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants and types for the LZSS window decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  // Default build limits
  localparam int WINDOW_BITS_MAX_DEF = 12;
  localparam int LENGTH_BITS_MAX_DEF = 5;

  // Widths of the effective (clamped) field widths and the token bit counter
  localparam int EWB_W = 5;
  localparam int ELB_W = 3;
  localparam int CNT_W = 5;

  // Configuration register widths and reset values
  localparam int CFG_WB_W   = 4;
  localparam int CFG_LB_W   = 3;
  localparam int CFG_LA_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_WB_W-1:0] CFG_WB_RST = 4'd11;
  localparam logic [CFG_LB_W-1:0] CFG_LB_RST = 3'd4;
  localparam logic [CFG_LA_W-1:0] CFG_LA_RST = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW_BITS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LENGTH_BITS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOOKAHEAD_EXTRA = 2'd2;

  // Lower clamps of the field widths
  localparam logic [EWB_W-1:0] WB_MIN = 5'd8;
  localparam logic [ELB_W-1:0] LB_MIN = 3'd2;

  localparam logic [CNT_W-1:0] LIT_BITS = 5'd8;
  localparam logic [CNT_W-1:0] CNT_SAT  = 5'd31;

  localparam logic [7:0] FILL_CHAR = 8'h20;

  // Token completion events from the bit parser
  typedef struct packed {
    logic lit;
    logic match;
  } lzwd_tok_ev_t;

endpackage

[rtl/core/lzwd_window_ram.sv]
// ----------------------------------------------------------------------------
// lzwd_window_ram
// History window: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lzwd_window_ram #(
  parameter int AW = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  localparam int DEPTH = 1 << AW;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/lzwd_bit_parser.sv]
// ----------------------------------------------------------------------------
// lzwd_bit_parser
// Serial token parser: takes one compressed bit per step, flags a literal
// or a match when its last field bit arrives.
// ----------------------------------------------------------------------------
module lzwd_bit_parser #(
  parameter int WINDOW_BITS_MAX = 12,
  parameter int LENGTH_BITS_MAX = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic                            restart_i,
  input  logic                            bit_i,
  input  logic [lzwd_pkg::EWB_W-1:0]      wbe_i,
  input  logic [lzwd_pkg::ELB_W-1:0]      lbe_i,
  input  logic [WINDOW_BITS_MAX-1:0]      wmask_i,
  output lzwd_pkg::lzwd_tok_ev_t          ev_o,
  output logic [7:0]                      lit_o,
  output logic [WINDOW_BITS_MAX-1:0]      pos_o,
  output logic [LENGTH_BITS_MAX-1:0]      len_o
);
  import lzwd_pkg::*;

  localparam int TW = WINDOW_BITS_MAX + LENGTH_BITS_MAX;

  localparam logic [1:0] KIND_FLAG  = 2'd0;
  localparam logic [1:0] KIND_LIT   = 2'd1;
  localparam logic [1:0] KIND_MATCH = 2'd2;

  logic [1:0]       kind_q, kind_d;
  logic [TW-1:0]    tok_q, tok_d, tok_n;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_n;
  logic [CNT_W-1:0] need;
  logic [TW-1:0]    pos_full;
  logic [LENGTH_BITS_MAX:0] lone;
  logic             is_flag;

  assign is_flag  = (kind_q != KIND_LIT) && (kind_q != KIND_MATCH);
  assign tok_n    = {tok_q[TW-2:0], bit_i};
  assign cnt_n    = (cnt_q == CNT_SAT) ? CNT_SAT : cnt_q + 1'b1;
  assign need     = CNT_W'(wbe_i) + CNT_W'(lbe_i);
  assign pos_full = tok_n >> lbe_i;
  assign lone     = (LENGTH_BITS_MAX+1)'(1) << lbe_i;

  assign pos_o     = pos_full[WINDOW_BITS_MAX-1:0] & wmask_i;
  assign len_o     = tok_n[LENGTH_BITS_MAX-1:0] & LENGTH_BITS_MAX'(lone - 1'b1);
  assign lit_o     = tok_n[7:0];
  assign ev_o.lit   = (kind_q == KIND_LIT) && (cnt_n >= LIT_BITS);
  assign ev_o.match = (kind_q == KIND_MATCH) && (cnt_n >= need);

  always_comb begin
    kind_d = kind_q;
    tok_d  = tok_q;
    cnt_d  = cnt_q;
    priority if (restart_i) begin
      kind_d = KIND_FLAG;
      tok_d  = '0;
      cnt_d  = '0;
    end else if (step_i && is_flag) begin
      kind_d = bit_i ? KIND_LIT : KIND_MATCH;
      tok_d  = '0;
      cnt_d  = '0;
    end else if (step_i) begin
      tok_d = tok_n;
      cnt_d = cnt_n;
      if (ev_o.lit || ev_o.match) begin
        kind_d = KIND_FLAG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_FLAG;
      tok_q  <= '0;
      cnt_q  <= '0;
    end else begin
      kind_q <= kind_d;
      tok_q  <= tok_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[rtl/core/lzss_window_decoder_unit.sv]
// ----------------------------------------------------------------------------
// lzss_window_decoder_unit
// LZSS decoder: bit-serial token parsing and byte-serial window copy.
// ----------------------------------------------------------------------------
//  port group   dir  payload (high bit first)         accepted when
//  s_axis       in   tdata: in_byte; tlast: stream_end tvalid & tready
//  m_axis       out  tdata: out_byte; tlast: run_last  tvalid & tready
//  cfg          in   idx: register, data: value        cfg_we_i
//
//  One input word passes an accept step, a parse step for each of its bits
//  and a wrap-up step, plus the steps of the token that it completes.
//  A literal adds an output step; each byte of a match adds a window read,
//  then an output load and window write.
//  Reset and every stream_end start a clearing pass over all 2^WINDOW_BITS_MAX
//  window entries that fills them with spaces; no word is taken meanwhile.
//  A stalled output holds the sequencer in its emit state.
// ----------------------------------------------------------------------------
module lzss_window_decoder_unit #(
  parameter int WINDOW_BITS_MAX = lzwd_pkg::WINDOW_BITS_MAX_DEF,
  parameter int LENGTH_BITS_MAX = lzwd_pkg::LENGTH_BITS_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] in_byte
  input  logic                              s_axis_tlast,  // stream_end
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [7:0] out_byte
  output logic                              m_axis_tlast,  // run_last
  input  logic                              cfg_we_i,
  input  logic [lzwd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lzwd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import lzwd_pkg::*;

  localparam int AW = WINDOW_BITS_MAX;
  localparam int CL_W = LENGTH_BITS_MAX + 1;

  // reset register values after clamping to the build limits
  localparam logic [EWB_W-1:0] WBE_RST = (int'(CFG_WB_RST) > WINDOW_BITS_MAX) ?
                                         EWB_W'(WINDOW_BITS_MAX) : EWB_W'(CFG_WB_RST);
  localparam logic [ELB_W-1:0] LBE_RST = (int'(CFG_LB_RST) > LENGTH_BITS_MAX) ?
                                         ELB_W'(LENGTH_BITS_MAX) : CFG_LB_RST;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_BITS  = 3'd2;
  localparam logic [2:0] S_LIT   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_RDW   = 3'd5;
  localparam logic [2:0] S_END   = 3'd6;

  function automatic logic [AW-1:0] start_pos(input logic [EWB_W-1:0] wbe,
                                               input logic [ELB_W-1:0] lbe,
                                               input logic [1:0]       la);
    logic [AW:0] size;
    logic [AW:0] span;
    size = (AW+1)'(1) << wbe;
    span = ((AW+1)'(1) << lbe) + (AW+1)'(la);
    return AW'(size - span);
  endfunction

  logic [CFG_WB_W-1:0] cfg_wb_q;
  logic [CFG_LB_W-1:0] cfg_lb_q;
  logic [CFG_LA_W-1:0] cfg_la_q;

  logic [2:0]      state_q, state_d;
  logic [7:0]      sh_q, sh_d;
  logic [3:0]      bits_left_q, bits_left_d;
  logic            end_q, end_d;
  logic [7:0]      lit_q, lit_d;
  logic [AW-1:0]   rd_addr_q, rd_addr_d;
  logic [CL_W-1:0] copy_left_q, copy_left_d;
  logic [AW-1:0]   wp_q, wp_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic            m_valid_q, m_valid_d;
  logic [7:0]      m_data_q, m_data_d;
  logic            m_last_q, m_last_d;

  logic [EWB_W-1:0] wbe;
  logic [ELB_W-1:0] lbe;
  logic [AW:0]      wone;
  logic [AW-1:0]    wmask;

  logic                       p_step, p_restart;
  lzwd_tok_ev_t               p_ev;
  logic [7:0]                 p_lit;
  logic [AW-1:0]              p_pos;
  logic [LENGTH_BITS_MAX-1:0] p_len;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic       out_free, out_load, out_last;
  logic [7:0] emit_byte;
  logic [2:0] after_tok;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_wb_q <= CFG_WB_RST;
      cfg_lb_q <= CFG_LB_RST;
      cfg_la_q <= CFG_LA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_WINDOW_BITS:     cfg_wb_q <= cfg_data_i[CFG_WB_W-1:0];
        CFG_IDX_LENGTH_BITS:     cfg_lb_q <= cfg_data_i[CFG_LB_W-1:0];
        CFG_IDX_LOOKAHEAD_EXTRA: cfg_la_q <= cfg_data_i[CFG_LA_W-1:0];
        default: ;
      endcase
    end
  end

  // effective widths
  always_comb begin
    priority if (EWB_W'(cfg_wb_q) < WB_MIN) begin
      wbe = WB_MIN;
    end else if (EWB_W'(cfg_wb_q) > EWB_W'(WINDOW_BITS_MAX)) begin
      wbe = EWB_W'(WINDOW_BITS_MAX);
    end else begin
      wbe = EWB_W'(cfg_wb_q);
    end
    priority if (cfg_lb_q < LB_MIN) begin
      lbe = LB_MIN;
    end else if (cfg_lb_q > ELB_W'(LENGTH_BITS_MAX)) begin
      lbe = ELB_W'(LENGTH_BITS_MAX);
    end else begin
      lbe = cfg_lb_q;
    end
  end

  assign wone  = (AW+1)'(1) << wbe;
  assign wmask = AW'(wone - 1'b1);

  lzwd_bit_parser #(
    .WINDOW_BITS_MAX (WINDOW_BITS_MAX),
    .LENGTH_BITS_MAX (LENGTH_BITS_MAX)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (p_step),
    .restart_i (p_restart),
    .bit_i     (sh_q[7]),
    .wbe_i     (wbe),
    .lbe_i     (lbe),
    .wmask_i   (wmask),
    .ev_o      (p_ev),
    .lit_o     (p_lit),
    .pos_o     (p_pos),
    .len_o     (p_len)
  );

  lzwd_window_ram #(
    .AW (AW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  assign out_free  = !m_valid_q || m_axis_tready;
  assign out_load  = ((state_q == S_LIT) || (state_q == S_RDW)) && out_free;
  assign emit_byte = (state_q == S_LIT) ? lit_q : ram_rdata;
  assign out_last  = (state_q == S_LIT) || (copy_left_q == '0);
  assign after_tok = (bits_left_q == '0) ? S_END : S_BITS;

  assign p_step    = (state_q == S_BITS);
  assign p_restart = (state_q == S_END) && end_q;

  assign ram_re    = (state_q == S_RD);
  assign ram_we    = (state_q == S_CLEAR) || out_load;
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : (wp_q & wmask);
  assign ram_wdata = (state_q == S_CLEAR) ? FILL_CHAR : emit_byte;

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    sh_d        = sh_q;
    bits_left_d = bits_left_q;
    end_d       = end_q;
    lit_d       = lit_q;
    rd_addr_d   = rd_addr_q;
    copy_left_d = copy_left_q;
    wp_d        = wp_q;
    clr_d       = clr_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;
    m_last_d    = m_last_q;

    if (out_load) begin
      m_valid_d = 1'b1;
      m_data_d  = emit_byte;
      m_last_d  = out_last;
      wp_d      = (wp_q + 1'b1) & wmask;
    end

    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          sh_d        = s_axis_tdata;
          end_d       = s_axis_tlast;
          bits_left_d = 4'd8;
          state_d     = S_BITS;
        end
      end
      S_BITS: begin
        sh_d        = {sh_q[6:0], 1'b0};
        bits_left_d = bits_left_q - 1'b1;
        priority if (p_ev.lit) begin
          lit_d   = p_lit;
          state_d = S_LIT;
        end else if (p_ev.match) begin
          rd_addr_d   = p_pos;
          copy_left_d = CL_W'(p_len) + 1'b1;
          state_d     = S_RD;
        end else if (bits_left_q == 4'd1) begin
          state_d = S_END;
        end
      end
      S_LIT: begin
        if (out_free) begin
          state_d = after_tok;
        end
      end
      S_RD: begin
        state_d = S_RDW;
      end
      S_RDW: begin
        if (out_free) begin
          rd_addr_d   = (rd_addr_q + 1'b1) & wmask;
          copy_left_d = copy_left_q - 1'b1;
          state_d     = (copy_left_q == '0) ? after_tok : S_RD;
        end
      end
      S_END: begin
        if (end_q) begin
          wp_d    = start_pos(wbe, lbe, cfg_la_q);
          clr_d   = '0;
          state_d = S_CLEAR;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      bits_left_q <= '0;
      end_q       <= 1'b0;
      copy_left_q <= '0;
      wp_q        <= start_pos(WBE_RST, LBE_RST, CFG_LA_RST);
      clr_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      bits_left_q <= bits_left_d;
      end_q       <= end_d;
      copy_left_q <= copy_left_d;
      wp_q        <= wp_d;
      clr_q       <= clr_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q      <= sh_d;
    lit_q     <= lit_d;
    rd_addr_q <= rd_addr_d;
    m_data_q  <= m_data_d;
    m_last_q  <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // a word must never overwrite a pending output word
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output word overwritten");

  // window read and write never share a cycle (copy overlap ordering)
  a_ram_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("window read and write collide");

  // parsing only while bits of the current word remain
  a_bits_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BITS) |-> (bits_left_q != '0))
    else $error("parse step without input bits");

  // clearing pass runs over the whole window before going idle
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) && (state_d == S_IDLE) |-> (clr_q == '1))
    else $error("clearing pass cut short");

endmodule
